// ----- sv/lrpw_pkg.sv -----
// Shared types, constants and helpers for the line rasterizer pixel writer.
package lrpw_pkg;

	// Default parameter values
	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_DIM_DEF    = 4096;
	localparam int QUEUE_DEPTH    = 4;

	// Field widths
	localparam int DIM_W    = 13;
	localparam int PITCH_W  = 15;
	localparam int FMT_W    = 2;
	localparam int COLOR_W  = 24;
	localparam int OFF_W    = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// Command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Pixel format codes
	localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB888 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_WORD32 = 2'd2;
	localparam logic [FMT_W-1:0] FMT_ALIAS  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd3;

	// Register reset values
	localparam logic [DIM_W-1:0]   RST_FB_WIDTH  = 13'd1024;
	localparam logic [DIM_W-1:0]   RST_FB_HEIGHT = 13'd768;
	localparam logic [PITCH_W-1:0] RST_ROW_PITCH = 15'd3072;

	typedef struct packed {
		logic [DIM_W-1:0]   fb_width;
		logic [DIM_W-1:0]   fb_height;
		logic [PITCH_W-1:0] row_pitch;
		logic [FMT_W-1:0]   pixel_format;
	} cfg_t;

	// Pack 0xRRGGBB for the given pixel format
	function automatic logic [COLOR_W-1:0] pack_color(input logic [COLOR_W-1:0] rgb,
			input logic [FMT_W-1:0] fmt);
		logic [COLOR_W-1:0] res;
		if (fmt == FMT_RGB565) begin
			res = {8'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
		end else begin
			res = rgb;
		end
		return res;
	endfunction

endpackage

// ----- sv/line_rasterizer_pixel_writer_unit.sv -----
// Line rasterizer pixel writer: Bresenham front end, pixel queue, offset back end.
// Throughput: one request per cycle while the pixel queue has room; each tick of an active line yields one pixel.
// A pixel's path after its tick is accepted: queue write, then the
// row-times-pitch multiply stage, then the output register.
// Input stalls only when the four-entry pixel queue is full.
// Reset (arst_n low) idles the line and empties the queue; registers take defaults.
module line_rasterizer_pixel_writer_unit import lrpw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_DIM    = MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [COLOR_W-1:0]           color_rgb,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         write_enable,
	output logic [OFF_W-1:0]             byte_offset,
	output logic [COLOR_W-1:0]           pixel_data,
	output logic                         last_pixel
);

	localparam int Q_W = 2 * COORD_BITS + COLOR_W + 1;

	cfg_t           cfg_q;
	logic           q_push;
	logic [Q_W-1:0] q_data;
	logic           q_full;
	logic           q_pop;
	logic           q_not_empty;
	logic [Q_W-1:0] q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width     <= RST_FB_WIDTH;
			cfg_q.fb_height    <= RST_FB_HEIGHT;
			cfg_q.row_pitch    <= RST_ROW_PITCH;
			cfg_q.pixel_format <= FMT_RGB888;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FB_WIDTH:     cfg_q.fb_width     <= cfg_wdata[DIM_W-1:0];
				REG_FB_HEIGHT:    cfg_q.fb_height    <= cfg_wdata[DIM_W-1:0];
				REG_ROW_PITCH:    cfg_q.row_pitch    <= cfg_wdata[PITCH_W-1:0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_wdata[FMT_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	lrpw_front #(
		.COORD_BITS(COORD_BITS),
		.Q_W       (Q_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.color_rgb(color_rgb),
		.q_push   (q_push),
		.q_data   (q_data),
		.q_full   (q_full)
	);

	lrpw_queue #(
		.W    (Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head_data(q_head)
	);

	lrpw_back #(
		.COORD_BITS(COORD_BITS),
		.MAX_DIM   (MAX_DIM),
		.Q_W       (Q_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_enable(write_enable),
		.byte_offset (byte_offset),
		.pixel_data  (pixel_data),
		.last_pixel  (last_pixel)
	);

endmodule

// ----- sv/lrpw_queue.sv -----
// Small register queue between the rasterizer front end and the pixel back end.
module lrpw_queue import lrpw_pkg::*; #(
	parameter int W     = 57,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_data = mem_q[rd_ptr_q];

	// Store incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/lrpw_front.sv -----
// Front end: accepts commands, holds the Bresenham state and queues pixels.
module lrpw_front import lrpw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int Q_W        = 2 * COORD_BITS + COLOR_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [COLOR_W-1:0]           color_rgb,
	output logic                         q_push,
	output logic [Q_W-1:0]               q_data,
	input  logic                         q_full
);

	localparam int ERR_W = COORD_BITS + 3;

	logic                         drawing_q;
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [COORD_BITS-1:0] goal_x_q;
	logic signed [COORD_BITS-1:0] goal_y_q;
	logic signed [ERR_W-1:0]      abs_dx_q;
	logic signed [ERR_W-1:0]      neg_dy_q;
	logic                         step_x_neg_q;
	logic                         step_y_neg_q;
	logic signed [ERR_W-1:0]      err_q;
	logic [COLOR_W-1:0]           color_q;

	logic                         accept;
	logic                         is_last;
	logic signed [ERR_W-1:0]      dx_raw;
	logic signed [ERR_W-1:0]      dy_raw;
	logic signed [ERR_W-1:0]      abs_dx_new;
	logic signed [ERR_W-1:0]      abs_dy_new;
	logic signed [ERR_W:0]        e2;
	logic                         move_x;
	logic                         move_y;
	logic signed [ERR_W-1:0]      err_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_last  = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);

	// Emit one pixel per tick while a line is active
	assign q_push = accept && (cmd == CMD_TICK) && drawing_q;
	assign q_data = {cur_x_q, cur_y_q, color_q, is_last};

	// Set up deltas for a new line
	always_comb begin
		dx_raw     = ERR_W'(x_end) - ERR_W'(x_start);
		dy_raw     = ERR_W'(y_end) - ERR_W'(y_start);
		abs_dx_new = dx_raw[ERR_W-1] ? -dx_raw : dx_raw;
		abs_dy_new = dy_raw[ERR_W-1] ? -dy_raw : dy_raw;
	end

	// Bresenham step decision
	always_comb begin
		e2       = {err_q, 1'b0};
		move_x   = (e2 >= (ERR_W + 1)'(neg_dy_q));
		move_y   = (e2 <= (ERR_W + 1)'(abs_dx_q));
		err_next = err_q + (move_x ? neg_dy_q : '0) + (move_y ? abs_dx_q : '0);
	end

	// Line state: latch on start, advance on each emitted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drawing_q <= 1'b0;
		end else if (accept) begin
			if (cmd == CMD_START) begin
				drawing_q <= 1'b1;
			end else if (drawing_q && is_last) begin
				drawing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd == CMD_START) begin
				cur_x_q      <= x_start;
				cur_y_q      <= y_start;
				goal_x_q     <= x_end;
				goal_y_q     <= y_end;
				abs_dx_q     <= abs_dx_new;
				neg_dy_q     <= -abs_dy_new;
				step_x_neg_q <= !(x_start < x_end);
				step_y_neg_q <= !(y_start < y_end);
				err_q        <= abs_dx_new - abs_dy_new;
				color_q      <= pack_color(color_rgb, cfg.pixel_format);
			end else if (drawing_q && !is_last) begin
				err_q <= err_next;
				if (move_x) begin
					cur_x_q <= step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				end
				if (move_y) begin
					cur_y_q <= step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/lrpw_back.sv -----
// Back end: clips each queued pixel, forms its byte offset and drives the result.
module lrpw_back import lrpw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int Q_W        = 2 * COORD_BITS + COLOR_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_not_empty,
	input  logic [Q_W-1:0]     q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               write_enable,
	output logic [OFF_W-1:0]   byte_offset,
	output logic [COLOR_W-1:0] pixel_data,
	output logic               last_pixel
);

	localparam int XW     = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
	localparam int PROD_W = DIM_W + PITCH_W;
	localparam int XB_W   = DIM_W + 2;

	logic                         advance;
	logic signed [COORD_BITS-1:0] hx;
	logic signed [COORD_BITS-1:0] hy;
	logic [DIM_W-1:0]             w_eff;
	logic [DIM_W-1:0]             h_eff;
	logic [DIM_W-1:0]             col;
	logic [DIM_W-1:0]             row;
	logic                         in_view;
	logic [XB_W-1:0]              col_bytes;

	logic                         valid_s1;
	logic                         inside_s1;
	logic [PROD_W-1:0]            prod_s1;
	logic [XB_W-1:0]              col_bytes_s1;
	logic [COLOR_W-1:0]           color_s1;
	logic                         last_s1;

	logic                         valid_s2;
	logic                         inside_s2;
	logic [OFF_W-1:0]             off_s2;
	logic [COLOR_W-1:0]           color_s2;
	logic                         last_s2;

	// Move the whole pipe when the output slot is free or taken
	assign advance = !valid_s2 || out_ready;
	assign q_pop   = advance && q_not_empty;

	assign hx  = q_head[Q_W-1 -: COORD_BITS];
	assign hy  = q_head[Q_W-1-COORD_BITS -: COORD_BITS];
	assign col = DIM_W'($unsigned(hx));
	assign row = DIM_W'($unsigned(hy));

	// Clip against the visible area, sizes limited to the largest dimension
	always_comb begin
		w_eff   = (32'(cfg.fb_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.fb_width;
		h_eff   = (32'(cfg.fb_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.fb_height;
		in_view = !hx[COORD_BITS-1] && (XW'($unsigned(hx)) < XW'(w_eff))
			&& !hy[COORD_BITS-1] && (XW'($unsigned(hy)) < XW'(h_eff));
	end

	// Column times bytes per pixel
	always_comb begin
		case (cfg.pixel_format) inside
			FMT_RGB565:            col_bytes = {1'b0, col, 1'b0};
			FMT_RGB888:            col_bytes = {1'b0, col, 1'b0} + XB_W'(col);
			FMT_WORD32, FMT_ALIAS: col_bytes = {col, 2'b00};
			default:               col_bytes = {col, 2'b00};
		endcase
	end

	// Stage 1: row times pitch, clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s1    <= in_view;
			prod_s1      <= PROD_W'(row) * PROD_W'(cfg.row_pitch);
			col_bytes_s1 <= col_bytes;
			color_s1     <= q_head[COLOR_W:1];
			last_s1      <= q_head[0];
		end
	end

	// Stage 2: sum offset, zero for clipped pixels; hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			inside_s2 <= inside_s1;
			off_s2    <= inside_s1 ? (OFF_W'(prod_s1) + OFF_W'(col_bytes_s1)) : '0;
			color_s2  <= color_s1;
			last_s2   <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = inside_s2;
	assign byte_offset  = off_s2;
	assign pixel_data   = color_s2;
	assign last_pixel   = last_s2;

endmodule

// ----- sv/lrpw_checker.sv -----
// Port-level checks for the line rasterizer pixel writer, bound to the top level.
module lrpw_checker import lrpw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               write_enable,
	input logic [OFF_W-1:0]   byte_offset,
	input logic [COLOR_W-1:0] pixel_data,
	input logic               last_pixel
);

	// A stalled result stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(byte_offset) && $stable(pixel_data)
			&& $stable(write_enable) && $stable(last_pixel))
		else $error("result payload changed while stalled");

	// A clipped pixel carries a zero offset
	a_clip_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> byte_offset == '0)
		else $error("clipped pixel with nonzero offset");

	// No result is offered and the input stays ready once reset has taken hold
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !out_valid && in_ready)
		else $error("activity during reset");

endmodule

bind line_rasterizer_pixel_writer_unit lrpw_checker u_lrpw_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the line rasterizer pixel writer: table-driven and random lines.
`timescale 1ns / 100ps

module tb_top import lrpw_pkg::*; ();

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int LONG_HOLD       = 80;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int MAX_PRINTS      = 100;
	localparam int CW              = COORD_BITS_DEF;

	typedef struct packed {
		logic               cmd;
		logic [CW-1:0]      x0;
		logic [CW-1:0]      y0;
		logic [CW-1:0]      x1;
		logic [CW-1:0]      y1;
		logic [COLOR_W-1:0] rgb;
	} raster_req_t;

	typedef struct packed {
		logic               we;
		logic [OFF_W-1:0]   off;
		logic [COLOR_W-1:0] data;
		logic               last;
	} pixel_t;

	typedef struct packed {
		raster_req_t req;
		logic        typed;
		pixel_t      px;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  cmd = CMD_TICK;
	logic [CW-1:0]         x_start = '0;
	logic [CW-1:0]         y_start = '0;
	logic [CW-1:0]         x_end = '0;
	logic [CW-1:0]         y_end = '0;
	logic [COLOR_W-1:0]    color_rgb = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  write_enable;
	logic [OFF_W-1:0]      byte_offset;
	logic [COLOR_W-1:0]    pixel_data;
	logic                  last_pixel;

	// Predictor copy of the registers and the line state
	int         cfg_width = 1024;
	int         cfg_height = 768;
	int         cfg_pitch = 3072;
	logic [1:0] cfg_fmt = FMT_RGB888;
	bit         ln_active = 1'b0;
	int         pos_x = 0, pos_y = 0, end_x = 0, end_y = 0;
	int         span_x = 0, span_y_neg = 0, err_acc = 0;
	bit         dir_x_neg = 1'b0, dir_y_neg = 1'b0;
	logic [COLOR_W-1:0] line_color = '0;

	pixel_t expected_px[$];
	int     mismatch_cnt = 0;
	int     phase_items = 0;
	int     stall_cycles = 0;
	bit     burst = 1'b0;
	int     hold_req = 0;
	int     hold_ack = 0;

	stim_row_t dir_tbl [25];

	line_rasterizer_pixel_writer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.color_rgb   (color_rgb),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_enable(write_enable),
		.byte_offset (byte_offset),
		.pixel_data  (pixel_data),
		.last_pixel  (last_pixel)
	);

	always #5 clk = ~clk;

	function automatic int mag(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int bytes_pp();
		case (cfg_fmt)
			FMT_RGB565: return 2;
			FMT_RGB888: return 3;
			default:    return 4;
		endcase
	endfunction

	// Pack 0xRRGGBB for the format in force when the line starts
	function automatic logic [COLOR_W-1:0] to_pixel_color(logic [COLOR_W-1:0] rgb);
		int r, g, b;
		r = int'(rgb[23:16]);
		g = int'(rgb[15:8]);
		b = int'(rgb[7:0]);
		if (cfg_fmt == FMT_RGB565)
			return COLOR_W'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
		return rgb;
	endfunction

	// Advance the line state by one request; return 1 when a pixel comes out
	function automatic bit rasterize(raster_req_t r, output pixel_t px);
		int lim_w, lim_h, e2;
		longint ofs;
		bit on_fb;
		px = '0;
		if (r.cmd == CMD_START) begin
			pos_x = int'($signed(r.x0));
			pos_y = int'($signed(r.y0));
			end_x = int'($signed(r.x1));
			end_y = int'($signed(r.y1));
			span_x = end_x > pos_x ? end_x - pos_x : pos_x - end_x;
			span_y_neg = -(end_y > pos_y ? end_y - pos_y : pos_y - end_y);
			dir_x_neg = !(pos_x < end_x);
			dir_y_neg = !(pos_y < end_y);
			err_acc = span_x + span_y_neg;
			line_color = to_pixel_color(r.rgb);
			ln_active = 1'b1;
			return 1'b0;
		end
		if (!ln_active)
			return 1'b0;

		// Clip against the visible area, sizes capped at the maximum dimension
		lim_w = cfg_width > MAX_DIM_DEF ? MAX_DIM_DEF : cfg_width;
		lim_h = cfg_height > MAX_DIM_DEF ? MAX_DIM_DEF : cfg_height;
		on_fb = pos_x >= 0 && pos_x < lim_w && pos_y >= 0 && pos_y < lim_h;
		px.we = on_fb;
		px.data = line_color;
		px.last = (pos_x == end_x) && (pos_y == end_y);
		if (on_fb) begin
			ofs = longint'(pos_y) * cfg_pitch + longint'(pos_x) * bytes_pp();
			px.off = ofs[OFF_W-1:0];
		end

		// Take one Bresenham step unless this was the end point
		if (px.last) begin
			ln_active = 1'b0;
		end else begin
			e2 = 2 * err_acc;
			if (e2 >= span_y_neg) begin
				err_acc += span_y_neg;
				pos_x += dir_x_neg ? -1 : 1;
			end
			if (e2 <= span_x) begin
				err_acc += span_x;
				pos_y += dir_y_neg ? -1 : 1;
			end
		end
		return 1'b1;
	endfunction

	// Table helpers: start, tick checked by the predictor, tick with a typed pixel
	function automatic stim_row_t st(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] rgb);
		stim_row_t row;
		row = '0;
		row.req = '{CMD_START, CW'(x0), CW'(y0), CW'(x1), CW'(y1), rgb};
		return row;
	endfunction

	function automatic stim_row_t tk();
		stim_row_t row;
		row = '0;
		row.req.cmd = CMD_TICK;
		return row;
	endfunction

	function automatic stim_row_t tk_px(logic we, int off, logic [COLOR_W-1:0] data, logic last);
		stim_row_t row;
		row = tk();
		row.typed = 1'b1;
		row.px = '{we, OFF_W'(off), data, last};
		return row;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coordinate near the origin, near the far edge, or anywhere inside
	function automatic int near_edge(int lim);
		case ($urandom_range(0, 3))
			0:       return int'($urandom_range(0, 12)) - 6;
			1:       return lim + int'($urandom_range(0, 12)) - 6;
			default: return lim > 0 ? int'($urandom_range(0, lim - 1)) : 0;
		endcase
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 3))
			0:       return -32768;
			1:       return 32767;
			2:       return 0;
			default: return -1;
		endcase
	endfunction

	task automatic flag_mismatch(string fld, longint got, longint want);
		if (mismatch_cnt < MAX_PRINTS)
			$display("%0t: pixel mismatch on %s: got 0x%0h, want 0x%0h", $time, fld, got, want);
		mismatch_cnt++;
	endtask

	// Offer one request, hold it until accepted, then queue its expected pixel
	task automatic drive_req(raster_req_t r, bit typed, pixel_t typed_px);
		int gap;
		pixel_t px;
		bit got;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= r.cmd;
		x_start   <= r.x0;
		y_start   <= r.y0;
		x_end     <= r.x1;
		y_end     <= r.y1;
		color_rgb <= r.rgb;
		do @(posedge clk); while (!in_ready);
		got = rasterize(r, px);
		if (typed)
			expected_px.push_back(typed_px);
		else if (got)
			expected_px.push_back(px);
		phase_items++;
	endtask

	// Drop valid and wait until every expected pixel has come out
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_FB_WIDTH:  cfg_width = int'(data[DIM_W-1:0]);
			REG_FB_HEIGHT: cfg_height = int'(data[DIM_W-1:0]);
			REG_ROW_PITCH: cfg_pitch = int'(data[PITCH_W-1:0]);
			default:       cfg_fmt = data[FMT_W-1:0];
		endcase
		@(posedge clk);
	endtask

	// Program the registers for one phase: extremes first, then random small frames
	task automatic apply_phase_cfg(int ph);
		int w, h, p;
		logic [CFG_DATA_W-1:0] fmt_word;
		settle();
		case (ph)
			0: begin
				w = 4096; h = 4096; p = 16384; fmt_word = CFG_DATA_W'(FMT_RGB565);
			end
			1: begin
				w = 1; h = 1; p = 1; fmt_word = CFG_DATA_W'(FMT_WORD32);
			end
			2: begin
				w = 0; h = 8191; p = 32767; fmt_word = CFG_DATA_W'(FMT_ALIAS);
			end
			3: begin
				w = 'h7FFF; h = 0; p = 0; fmt_word = CFG_DATA_W'(FMT_RGB888);
			end
			4: begin
				w = 4096; h = 4096; p = 32767; fmt_word = CFG_DATA_W'(FMT_RGB888);
			end
			5: begin
				w = 4095; h = 4097; p = 12345; fmt_word = CFG_DATA_W'(FMT_RGB565);
			end
			default: begin
				w = $urandom_range(1, 80);
				h = $urandom_range(1, 80);
				p = $urandom_range(0, 32767);
				fmt_word = CFG_DATA_W'($urandom_range(0, 32767));
			end
		endcase
		write_reg(REG_FB_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_FB_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_ROW_PITCH, CFG_DATA_W'(p));
		write_reg(REG_PIXEL_FORMAT, fmt_word);
		cfg_we <= 1'b0;
	endtask

	// One random stroke: mostly short lines (some abandoned), random or extreme lines, or noise
	task automatic random_stroke();
		int kind, x0, y0, x1, y1, n, ticks, lw, lh;
		raster_req_t r;
		kind = $urandom_range(0, 99);
		lw = cfg_width > MAX_DIM_DEF ? MAX_DIM_DEF : cfg_width;
		lh = cfg_height > MAX_DIM_DEF ? MAX_DIM_DEF : cfg_height;
		if (kind < 70) begin
			x0 = near_edge(lw);
			y0 = near_edge(lh);
			x1 = x0 + int'($urandom_range(0, 24)) - 12;
			y1 = y0 + int'($urandom_range(0, 24)) - 12;
			n = (mag(x1 - x0) > mag(y1 - y0) ? mag(x1 - x0) : mag(y1 - y0)) + 1;
			if ($urandom_range(0, 9) == 0)
				ticks = $urandom_range(0, n - 1);
			else
				ticks = n + int'($urandom_range(0, 1));
		end else if (kind < 80) begin
			x0 = $urandom;
			y0 = $urandom;
			x1 = $urandom;
			y1 = $urandom;
			ticks = $urandom_range(0, 6);
		end else if (kind < 90) begin
			x0 = pick_extreme();
			y0 = pick_extreme();
			x1 = pick_extreme();
			y1 = pick_extreme();
			if ($urandom_range(0, 3) == 0) begin
				x1 = x0;
				y1 = y0;
			end
			ticks = $urandom_range(0, 4);
		end else begin
			// Noise: fully random requests, starts and ticks alike
			repeat ($urandom_range(1, 3)) begin
				r = $bits(raster_req_t)'({$urandom, $urandom, $urandom});
				drive_req(r, 1'b0, '0);
			end
			return;
		end
		r = '{CMD_START, CW'(x0), CW'(y0), CW'(x1), CW'(y1), COLOR_W'($urandom)};
		drive_req(r, 1'b0, '0);
		r.cmd = CMD_TICK;
		repeat (ticks) begin
			r.rgb = COLOR_W'($urandom);
			drive_req(r, 1'b0, '0);
		end
	endtask

	// Stimulus: reset, directed table, then random phases over several settings
	initial begin
		dir_tbl = '{
			tk(),
			st(0, 0, 0, 0, 24'hFFFFFF),
			tk_px(1'b1, 0, 24'hFFFFFF, 1'b1),
			tk(),
			st(1023, 767, 1023, 767, 24'h000000),
			tk_px(1'b1, 2359293, 24'h000000, 1'b1),
			st(1024, 0, 1024, 0, 24'h123456),
			tk_px(1'b0, 0, 24'h123456, 1'b1),
			st(-1, -1, -1, -1, 24'h654321),
			tk_px(1'b0, 0, 24'h654321, 1'b1),
			st(0, 0, 3, 1, 24'hABCDEF),
			tk(), tk(), tk(), tk(),
			st(10, 10, 2, 14, 24'h00FF00),
			tk(), tk(),
			st(-32768, -32768, 32767, 32767, 24'h800001),
			tk_px(1'b0, 0, 24'h800001, 1'b0),
			tk(),
			st(32767, -32768, -32768, 32767, 24'h7F7F7F),
			tk(),
			st(5, 767, 5, 764, 24'h0000FF),
			tk()
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i])
			drive_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].px);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			apply_phase_cfg(ph);
			burst = (ph % 3 == 0);
			// Stall the receiver for a long stretch while requests keep coming
			if (ph == 0)
				hold_req++;
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE)
				random_stroke();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold on request
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_ack != hold_req) begin
				hold_ack = hold_req;
				n = LONG_HOLD;
			end else if (burst) begin
				n = 0;
			end else begin
				n = pick_gap();
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare each accepted pixel with the oldest expectation
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_px.size() == 0) begin
				flag_mismatch("unexpected pixel, byte_offset", byte_offset, 0);
			end else begin
				want = expected_px.pop_front();
				if (write_enable !== want.we)
					flag_mismatch("write_enable", write_enable, want.we);
				if (byte_offset !== want.off)
					flag_mismatch("byte_offset", byte_offset, want.off);
				if (pixel_data !== want.data)
					flag_mismatch("pixel_data", pixel_data, want.data);
				if (last_pixel !== want.last)
					flag_mismatch("last_pixel", last_pixel, want.last);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule

// ----- sim.f -----
sv/lrpw_pkg.sv
sv/lrpw_queue.sv
sv/lrpw_front.sv
sv/lrpw_back.sv
sv/line_rasterizer_pixel_writer_unit.sv
sv/lrpw_checker.sv
sim/tb_top.sv
